>>> src/mfnw_pkg.sv
// ----------------------------------------------------------------------------
// mfnw_pkg
// shared widths, constants, the request beat type and the queue status type of the nack window unit
// ----------------------------------------------------------------------------
`default_nettype none

package mfnw_pkg;

	localparam int unsigned IDX_W   = 16;
	localparam int unsigned TAG_W   = 64;
	localparam int unsigned MASK_W  = 64;

	// slots left past the scan point above which a full window stops the scan
	localparam logic [IDX_W:0] STOP_MARGIN = (IDX_W+1)'(128);

	// depth of the queue between scanner and output side
	localparam int unsigned QDEPTH  = 2;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [MASK_W-1:0] missing_mask;
		logic [IDX_W-1:0]  window_start;
		logic [TAG_W-1:0]  message_tag_out;
	} req_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
	} qstat_t;

endpackage

`default_nettype wire

>>> src/mfnw_scan.sv
// ----------------------------------------------------------------------------
// mfnw_scan
// front part: walks the fragment slots, builds windows, raises requests
// ----------------------------------------------------------------------------
`default_nettype none

module mfnw_scan #(
	parameter int unsigned WINDOW_BITS = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       take,
	input  wire logic                       present,
	input  wire logic                       first_slot,
	input  wire logic [mfnw_pkg::IDX_W-1:0] total_fragments,
	input  wire logic [mfnw_pkg::IDX_W-1:0] highest_received,
	input  wire logic [mfnw_pkg::TAG_W-1:0] message_tag,
	output logic                            push,
	output mfnw_pkg::req_t                  req
);

	localparam int unsigned BIT_W = $clog2(WINDOW_BITS);
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WINDOW_BITS - 1);

	logic [mfnw_pkg::IDX_W-1:0] pos_q, origin_q;
	logic [BIT_W-1:0]           bit_q;
	logic                       open_q, stopped_q;
	logic [WINDOW_BITS-1:0]     bits_q;

	// state as seen by this beat (a new message starts from reset values)
	logic [mfnw_pkg::IDX_W-1:0] pos_c, origin_c;
	logic [BIT_W-1:0]           bit_c;
	logic                       open_c, stopped_c;
	logic [WINDOW_BITS-1:0]     bits_c;

	logic                       skip, full, stop, emit;
	logic [mfnw_pkg::IDX_W-1:0] pos_n, origin_n;
	logic [WINDOW_BITS-1:0]     bits_n;
	logic                       open_n;
	logic [mfnw_pkg::IDX_W:0]   remain;

	always_comb begin
		pos_c     = first_slot ? '0 : pos_q;
		origin_c  = first_slot ? '0 : origin_q;
		bit_c     = first_slot ? '0 : bit_q;
		open_c    = first_slot ? 1'b0 : open_q;
		stopped_c = first_slot ? 1'b0 : stopped_q;
		bits_c    = first_slot ? '0 : bits_q;

		skip     = stopped_c || (pos_c >= total_fragments);
		open_n   = open_c || !present;
		origin_n = open_c ? origin_c : pos_c;
		bits_n   = (open_c ? bits_c : '0)
			| (present ? '0 : (WINDOW_BITS'(1) << bit_c));
		pos_n    = pos_c + 1'b1;
		full     = open_n && (bit_c == LAST_BIT);
		remain   = {1'b0, total_fragments} - {1'b0, pos_c};
		stop     = full && (pos_c > highest_received) && (remain > mfnw_pkg::STOP_MARGIN);
		emit     = !skip && (full || (open_n && (pos_n == total_fragments)));
	end

	assign push                = take && emit;
	assign req.message_tag_out = message_tag;
	assign req.window_start    = origin_n;
	assign req.missing_mask    = mfnw_pkg::MASK_W'(bits_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			origin_q  <= '0;
			bit_q     <= '0;
			open_q    <= 1'b0;
			stopped_q <= 1'b0;
			bits_q    <= '0;
		end else if (take) begin
			if (skip) begin
				// ignored slot; a new-message beat still clears state
				pos_q     <= pos_c;
				origin_q  <= origin_c;
				bit_q     <= bit_c;
				open_q    <= open_c;
				stopped_q <= stopped_c;
				bits_q    <= bits_c;
			end else begin
				pos_q     <= pos_n;
				origin_q  <= origin_n;
				stopped_q <= stop;
				if (emit) begin
					open_q <= 1'b0;
					bit_q  <= '0;
					bits_q <= '0;
				end else begin
					open_q <= open_n;
					bits_q <= bits_n;
					bit_q  <= open_n ? bit_c + 1'b1 : bit_c;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> src/mfnw_queue.sv
// ----------------------------------------------------------------------------
// mfnw_queue
// back part: short request queue with the master-side stream handshake
// ----------------------------------------------------------------------------
`default_nettype none

module mfnw_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mfnw_pkg::req_t wr_req,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mfnw_pkg::req_t      rd_req,
	output mfnw_pkg::qstat_t    stat
);

	mfnw_pkg::req_t                 mem [mfnw_pkg::QDEPTH];
	logic [mfnw_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [mfnw_pkg::QCNT_W-1:0]    count_q;
	logic                           pop;

	assign pop        = out_valid && out_ready;
	assign out_valid  = (count_q != '0);
	assign rd_req     = mem[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == mfnw_pkg::QCNT_W'(mfnw_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/missing_fragment_nack_windows_unit.sv
// ----------------------------------------------------------------------------
// missing_fragment_nack_windows_unit
// selective nack window builder for fragmented messages
// ----------------------------------------------------------------------------
// One beat per fragment slot, in slot order, is taken in every cycle while
// s_tready is high. The first missing slot opens a window of WINDOW_BITS
// slots; when the window is full, or at the last slot of the message, a
// request beat with the message tag, the window start and the missing mask
// is raised. A beat with first_slot set restarts the scan; once a window
// fills past the highest received index with more than 128 slots left, the
// rest of the message is ignored. The scanner settles each slot in the cycle
// it is taken, so the sustained rate is one slot per cycle while s_tready
// is high. Requests wait in a two-entry queue that feeds the master side,
// and s_tready drops only while that queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module missing_fragment_nack_windows_unit #(
	parameter int unsigned WINDOW_BITS = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// slot beats
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// present[0], total_fragments[16:1], highest_received[32:17],
	// message_tag[96:33], zero fill to 104 bits
	input  wire logic [103:0] s_tdata,
	// first_slot[0]
	input  wire logic         s_tuser,
	// request beats
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// message_tag_out[63:0], window_start[79:64], missing_mask[143:80]
	output logic [143:0]      m_tdata
);

	logic             take;
	logic             push;
	mfnw_pkg::req_t   scan_req;
	mfnw_pkg::req_t   out_req;
	mfnw_pkg::qstat_t qstat;

	// a valid slot is taken whenever the queue has room for a possible request
	assign s_tready = !qstat.full;
	assign take     = s_tvalid && s_tready;

	// front: per-slot window bookkeeping
	mfnw_scan #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.present         (s_tdata[0]),
		.first_slot      (s_tuser),
		.total_fragments (s_tdata[16:1]),
		.highest_received(s_tdata[32:17]),
		.message_tag     (s_tdata[96:33]),
		.push            (push),
		.req             (scan_req)
	);

	// back: request queue feeding the master side
	mfnw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_req   (scan_req),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.rd_req   (out_req),
		.stat     (qstat)
	);

	// pack the request beat, first field lowest
	assign m_tdata = {out_req.missing_mask, out_req.window_start, out_req.message_tag_out};

	// a request is never raised into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("request pushed into full queue");

	// every window opens on a missing slot, so its first bit is set
	a_mask_origin: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> scan_req.missing_mask[0])
		else $error("request without its opening bit");

	// the queue count stays within its depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= mfnw_pkg::QCNT_W'(mfnw_pkg::QDEPTH))
		else $error("queue count out of range");

	// a push into an empty queue shows on the master side next cycle
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !m_tvalid) |=> m_tvalid)
		else $error("pushed request not visible");

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the missing fragment nack window unit
// ----------------------------------------------------------------------------
// Slot beats go in on the slave stream. Each accepted beat runs through a
// software copy of the window scanner, which queues the request beats it
// should cause. Every request beat on the master stream is compared field by
// field with the oldest queued request. A directed opening covers the edge
// cases: single-slot messages, messages with no slots, an abandoned window,
// a full window with and without an early stop, and the widest field values.
// Random messages follow, mostly well formed, with broken and noisy runs
// mixed in. Both sides idle at random, and the output side holds off once
// for a long stretch so the internal request queue fills and stalls the input.
// ----------------------------------------------------------------------------

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN         = 64;
	localparam int LIVE_TARGET = 1200;
	localparam int LONG_STALL  = 400;
	localparam int DRAIN_LIMIT = 4000;

	// presence patterns for the slots of one message
	typedef enum int {
		PAT_ALL_MISSING,
		PAT_ALL_PRESENT,
		PAT_SPARSE,
		PAT_HALF,
		PAT_HOLE
	} pattern_t;

	// ------------------------------------------------------------------
	// window scanner prediction and the queue of requests it expects
	// ------------------------------------------------------------------
	class nack_scoreboard_t;
		mfnw_pkg::req_t                want_q[$];
		int                            errors;
		int                            checked;
		int                            stops;
		int                            windows;
		logic [mfnw_pkg::IDX_W:0]      slot_pos;
		logic [mfnw_pkg::IDX_W:0]      origin;
		logic [6:0]                    wbit;
		bit                            wopen;
		logic [mfnw_pkg::MASK_W-1:0]   gathered;
		bit                            stopped;

		function new();
			errors  = 0;
			checked = 0;
			stops   = 0;
			windows = 0;
			restart();
		endfunction

		function void restart();
			slot_pos = '0;
			origin   = '0;
			stopped  = 1'b0;
			shut();
		endfunction

		function void shut();
			wopen    = 1'b0;
			wbit     = '0;
			gathered = '0;
		endfunction

		function void queue_request(logic [mfnw_pkg::TAG_W-1:0] tag);
			mfnw_pkg::req_t r;
			r.message_tag_out = tag;
			r.window_start    = origin[mfnw_pkg::IDX_W-1:0];
			r.missing_mask    = gathered;
			want_q.push_back(r);
			windows++;
		endfunction

		// note one accepted slot beat; returns 1 when the beat was not ignored
		function bit note_slot(bit pres, bit first, logic [mfnw_pkg::IDX_W-1:0] tot,
				logic [mfnw_pkg::IDX_W-1:0] hi, logic [mfnw_pkg::TAG_W-1:0] tag);
			logic [mfnw_pkg::IDX_W:0] p;
			bit                       sent;
			sent = 1'b0;
			if (first)
				restart();
			if (stopped || slot_pos >= {1'b0, tot})
				return 1'b0;
			p = slot_pos;
			if (!pres) begin
				if (!wopen) begin
					wopen    = 1'b1;
					origin   = p;
					wbit     = '0;
					gathered = '0;
				end
				gathered |= {{(mfnw_pkg::MASK_W-1){1'b0}}, 1'b1} << wbit[5:0];
			end
			if (wopen) begin
				if (wbit >= 7'(WIN - 1)) begin
					// full window goes out once; far past the data it also ends the scan
					queue_request(tag);
					sent = 1'b1;
					if (p > {1'b0, hi} && ({1'b0, tot} - p) > mfnw_pkg::STOP_MARGIN) begin
						stopped = 1'b1;
						stops++;
					end
					shut();
				end else begin
					wbit++;
				end
			end
			slot_pos = p + 1'b1;
			// last slot of the message flushes a partial window
			if (!sent && wopen && slot_pos == {1'b0, tot}) begin
				queue_request(tag);
				shut();
			end
			return 1'b1;
		endfunction

		function void check_request(logic [143:0] raw);
			mfnw_pkg::req_t got;
			mfnw_pkg::req_t want;
			got = mfnw_pkg::req_t'(raw);
			if (want_q.size() == 0) begin
				$display("%0t: unexpected request, got tag %h start %h mask %h",
					$time, got.message_tag_out, got.window_start, got.missing_mask);
				errors++;
				return;
			end
			want = want_q.pop_front();
			checked++;
			if (got.message_tag_out !== want.message_tag_out) begin
				$display("%0t: message_tag_out expected %h actual %h",
					$time, want.message_tag_out, got.message_tag_out);
				errors++;
			end
			if (got.window_start !== want.window_start) begin
				$display("%0t: window_start expected %h actual %h",
					$time, want.window_start, got.window_start);
				errors++;
			end
			if (got.missing_mask !== want.missing_mask) begin
				$display("%0t: missing_mask expected %h actual %h",
					$time, want.missing_mask, got.missing_mask);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// block hookup
	// ------------------------------------------------------------------
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// present[0], total_fragments[16:1], highest_received[32:17],
	// message_tag[96:33], zero fill [103:97]
	logic [103:0] s_tdata;
	// first_slot[0]
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	// message_tag_out[63:0], window_start[79:64], missing_mask[143:80]
	logic [143:0] m_tdata;

	missing_fragment_nack_windows_unit #(
		.WINDOW_BITS(WIN)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	nack_scoreboard_t sb = new();

	// run bookkeeping
	int beats_sent  = 0;
	int live_beats  = 0;
	int long_stalls = 0;
	bit steady_tx   = 1'b0;   // sender runs without gaps while set
	bit stall_req   = 1'b0;   // asks the output side for one long hold-off

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("%0t: timeout, %0d requests still expected", $time, sb.want_q.size());
		$display("missing_fragment_nack_windows_unit verification failed");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic bit pick_present(pattern_t pat, int idx, int lo, int hi_end);
		case (pat)
			PAT_ALL_MISSING: return 1'b0;
			PAT_ALL_PRESENT: return 1'b1;
			PAT_SPARSE:      return $urandom_range(0, 9) != 0;
			PAT_HALF:        return 1'($urandom_range(0, 1));
			default:         return !(idx >= lo && idx <= hi_end);
		endcase
	endfunction

	function automatic logic [mfnw_pkg::TAG_W-1:0] pick_tag();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// one slot beat, held until it is taken, then fed to the prediction
	task automatic send_slot(bit pres, bit first, logic [mfnw_pkg::IDX_W-1:0] tot,
			logic [mfnw_pkg::IDX_W-1:0] hi, logic [mfnw_pkg::TAG_W-1:0] tag);
		int gap;
		gap = pick_gap(steady_tx);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, tag, hi, tot, pres};
		s_tuser  <= first;
		do
			@(posedge clk);
		while (!s_tready);
		beats_sent++;
		if (sb.note_slot(pres, first, tot, hi, tag))
			live_beats++;
	endtask

	// one message of n beats; after an early stop only a short tail follows
	task automatic send_message(logic [mfnw_pkg::IDX_W-1:0] tot,
			logic [mfnw_pkg::IDX_W-1:0] hi, logic [mfnw_pkg::TAG_W-1:0] tag, int n,
			pattern_t pat, int lo, int hi_end);
		int k;
		int tail;
		tail = -1;
		for (k = 0; k < n; k++) begin
			if (k > 0 && sb.stopped) begin
				if (tail < 0)
					tail = $urandom_range(0, 3);
				if (tail == 0)
					break;
				tail--;
			end
			send_slot(pick_present(pat, k, lo, hi_end), k == 0, tot, hi, tag);
		end
	endtask

	task automatic random_message();
		int                         r;
		int                         n;
		int                         lo;
		logic [mfnw_pkg::IDX_W-1:0] tot;
		logic [mfnw_pkg::IDX_W-1:0] hi;
		pattern_t                   pat;
		r   = $urandom_range(0, 99);
		pat = pattern_t'($urandom_range(0, 4));
		lo  = $urandom_range(0, 120);
		steady_tx = ($urandom_range(0, 4) == 0);
		if (r < 45) begin
			// short message, sometimes with a few ignored beats past its end
			tot = 16'($urandom_range(1, 70));
			hi  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, tot - 1));
			n   = tot + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			send_message(tot, hi, pick_tag(), n, pat, lo % tot,
				(lo % tot) + $urandom_range(0, 80));
		end else if (r < 60) begin
			tot = 16'($urandom_range(64, 200));
			hi  = 16'($urandom_range(0, tot - 1));
			send_message(tot, hi, pick_tag(), tot, pat, lo, lo + $urandom_range(0, 150));
		end else if (r < 72) begin
			// long message with little received, aimed at the early stop
			tot = 16'($urandom_range(129, 500));
			hi  = 16'($urandom_range(0, 60));
			if ($urandom_range(0, 1))
				send_message(tot, hi, pick_tag(), tot, PAT_ALL_MISSING, 0, 0);
			else
				send_message(tot, hi, pick_tag(), tot, PAT_HOLE, hi + 1, 1000);
		end else if (r < 86) begin
			// broken message: wide random sizes, abandoned early
			tot = ($urandom_range(0, 7) == 0) ? '0 : 16'($urandom);
			hi  = 16'($urandom);
			send_message(tot, hi, pick_tag(), $urandom_range(1, 30), pat, lo,
				lo + $urandom_range(0, 100));
		end else begin
			// noise: beats with unrelated fields on top of whatever scan is open
			n = $urandom_range(1, 8);
			repeat (n)
				send_slot(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
					16'($urandom), 16'($urandom), pick_tag());
		end
	endtask

	// output side idling, with one long hold-off on request
	initial begin : rx_side
		int g;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (stall_req) begin
				m_tready <= 1'b0;
				stall_req = 1'b0;
				repeat (LONG_STALL) @(posedge clk);
				long_stalls++;
			end else if ($urandom_range(0, 9) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end else begin
				g = pick_gap(1'b0);
				if (g > 0) begin
					m_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// request beats are checked at the edge that takes them
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_request(m_tdata);
	end

	initial begin : stimulus
		int k;
		int drain;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		arst_n   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-slot messages at the field extremes
		send_slot(1'b0, 1'b1, 16'd1, 16'd0, '1);
		send_slot(1'b1, 1'b1, 16'd1, 16'hffff, '0);
		// three slots, two missing, then a beat past the end that is ignored
		send_slot(1'b0, 1'b1, 16'd3, 16'd1, 64'h0123_4567_89ab_cdef);
		send_slot(1'b1, 1'b0, 16'd3, 16'd1, 64'h0123_4567_89ab_cdef);
		send_slot(1'b0, 1'b0, 16'd3, 16'd1, 64'h0123_4567_89ab_cdef);
		send_slot(1'b0, 1'b0, 16'd3, 16'd1, 64'h0123_4567_89ab_cdef);
		// message with no slots at all
		send_slot(1'b0, 1'b1, 16'd0, 16'd0, 64'h5555_5555_5555_5555);
		send_slot(1'b0, 1'b0, 16'd0, 16'd0, 64'h5555_5555_5555_5555);
		// open window dropped by a new message
		send_slot(1'b0, 1'b1, 16'd10, 16'd9, 64'haaaa_aaaa_aaaa_aaaa);
		send_slot(1'b0, 1'b0, 16'd10, 16'd9, 64'haaaa_aaaa_aaaa_aaaa);
		send_slot(1'b1, 1'b1, 16'd2, 16'd0, 64'h1);
		send_slot(1'b0, 1'b0, 16'd2, 16'd0, 64'h1);
		// widest sizes, abandoned after a few slots
		for (k = 0; k < 3; k++)
			send_slot(1'b0, k == 0, 16'hffff, 16'hffff, 64'h8000_0000_0000_0000);
		// full window far past the data: sent once, then the scan stops
		send_message(16'd300, 16'd5, 64'hfeed_0000_0000_0001, 300, PAT_HOLE, 6, 1000);
		// full window near the end of the message: no stop, partial flush after
		send_message(16'd70, 16'd0, 64'hfeed_0000_0000_0002, 70, PAT_ALL_MISSING, 0, 0);
		// full window while still below the highest received index
		send_message(16'd400, 16'd300, 64'hfeed_0000_0000_0003, 70, PAT_ALL_MISSING, 0, 0);

		// long output hold-off while one-slot missing messages keep coming
		stall_req = 1'b1;
		while (stall_req)
			@(posedge clk);
		steady_tx = 1'b1;
		for (k = 0; k < 40; k++)
			send_slot(1'b0, 1'b1, 16'd1, 16'(k), pick_tag());

		while (live_beats < LIVE_TARGET)
			random_message();

		s_tvalid <= 1'b0;
		s_tuser  <= 1'b0;

		// drain, then a short quiet stretch for any stray request
		drain = 0;
		while (sb.want_q.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (sb.want_q.size() != 0) begin
			$display("%0t: %0d expected requests never arrived", $time, sb.want_q.size());
			sb.errors++;
		end

		$display("run: %0d slot beats (%0d scanned), %0d requests checked",
			beats_sent, live_beats, sb.checked);
		$display("run: %0d early stops, %0d long output stalls, %0d errors",
			sb.stops, long_stalls, sb.errors);
		if (sb.errors == 0)
			$display("missing_fragment_nack_windows_unit verification clean");
		else
			$display("missing_fragment_nack_windows_unit verification failed");
		$finish;
	end

endmodule

>>> files.f
src/mfnw_pkg.sv
src/mfnw_scan.sv
src/mfnw_queue.sv
src/missing_fragment_nack_windows_unit.sv
dv/tb.sv
